// ----- src/all_pairs_shortest_path_assert.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the all-pairs shortest path engine
// Concurrent checks in simulation, empty bodies in synthesis.
// ---------------------------------------------------------------------------
`ifndef ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH
`define ALL_PAIRS_SHORTEST_PATH_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define APSP_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define APSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define APSP_ASSERT_IMPL(label, clk, rst, ante, cons, msg)

`define APSP_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

// ----- src/apsp_pkg.sv -----
// ---------------------------------------------------------------------------
// apsp_pkg
// Shared widths, command codes, controller states and control structs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package apsp_pkg;

   localparam int CMD_W    = 2;
   localparam int VERTEX_W = 6;
   localparam int WEIGHT_W = 16;
   localparam int DIST_W   = 22;
   localparam int VIA_W    = 7;
   localparam int COUNT_W  = 7;

   localparam logic [DIST_W-1:0]  DIST_INF           = 22'h3FFFFF;
   localparam logic [COUNT_W-1:0] VERTEX_COUNT_RESET = 7'd64;

   // request command codes
   localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RUN  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_READ = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROW,
      ST_PIVOT,
      ST_FETCH,
      ST_UPDATE
   } apsp_state_type;

   // controller -> datapath
   typedef struct packed {
      logic host_wr;    // load word into store
      logic host_rd;    // read pair for a response
      logic cnt_clear;  // zero k, i, j
      logic pivot_rd;   // read d[i][k]
      logic pivot_cap;  // latch d[i][k]
      logic pair_rd;    // read d[k][j] and d[i][j]
      logic relax;      // compare, write back, step counters
      logic finish;     // issue run-done response
   } apsp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic last_j;
      logic last_i;
      logic last_k;
      logic n_zero;
   } apsp_status_type;

endpackage

`default_nettype wire

// ----- src/apsp_ctrl.sv -----
// ---------------------------------------------------------------------------
// apsp_ctrl
// Sequencer: request decode and the k/i/j relaxation walk.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apsp_ctrl import apsp_pkg::*; (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [CMD_W-1:0] command,
   input  wire apsp_status_type  status,
   output logic                  busy,
   output apsp_cmd_type          cmd
);

   apsp_state_type state_ff;
   apsp_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               unique case (command)
                  CMD_LOAD: begin
                     cmd.host_wr = 1'b1;
                  end
                  CMD_READ: begin
                     cmd.host_rd = 1'b1;
                  end
                  CMD_RUN: begin
                     if (status.n_zero) begin
                        cmd.finish = 1'b1;
                     end else begin
                        cmd.cnt_clear = 1'b1;
                        state_in      = ST_ROW;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_ROW: begin
            cmd.pivot_rd = 1'b1;
            state_in     = ST_PIVOT;
         end
         ST_PIVOT: begin
            cmd.pivot_cap = 1'b1;
            cmd.pair_rd   = 1'b1;
            state_in      = ST_UPDATE;
         end
         ST_FETCH: begin
            cmd.pair_rd = 1'b1;
            state_in    = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.relax = 1'b1;
            if (!status.last_j) begin
               state_in = ST_FETCH;
            end else if (!status.last_i || !status.last_k) begin
               state_in = ST_ROW;
            end else begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- src/apsp_datapath.sv -----
// ---------------------------------------------------------------------------
// apsp_datapath
// Distance and via stores, loop counters, saturating relax and response.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module apsp_datapath import apsp_pkg::*; #(
   parameter int MAX_VERTICES = 64,
   parameter int WEIGHT_BITS  = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire apsp_cmd_type        cmd,
   output apsp_status_type          status,
   input  wire logic [VERTEX_W-1:0] req_row_vertex,
   input  wire logic [VERTEX_W-1:0] req_col_vertex,
   input  wire logic [WEIGHT_W-1:0] req_edge_weight,
   input  wire logic                csr_write_enable,
   input  wire logic [COUNT_W-1:0]  csr_write_data,
   output logic                     rsp_valid,
   output logic [DIST_W-1:0]        rsp_path_distance,
   output logic                     rsp_unreachable,
   output logic [VIA_W-1:0]         rsp_via_vertex,
   output logic                     rsp_run_done
);

   localparam int VW    = $clog2(MAX_VERTICES);
   localparam int AW    = 2 * VW;
   localparam int DEPTH = 1 << AW;
   localparam int NW    = $clog2(MAX_VERTICES + 1);
   localparam int CW    = (NW > COUNT_W) ? NW : COUNT_W;
   localparam logic [WEIGHT_W-1:0] WEIGHT_MASK =
      (WEIGHT_BITS >= WEIGHT_W) ? {WEIGHT_W{1'b1}}
                                : WEIGHT_W'((64'd1 << WEIGHT_BITS) - 64'd1);

   // config
   logic [COUNT_W-1:0] vertex_count_ff;
   logic [CW-1:0]      count_ext;
   logic [CW-1:0]      n_eff;
   logic [VW-1:0]      last_idx;

   // loop counters
   logic [VW-1:0] k_ff, i_ff, j_ff;
   logic [VW-1:0] k_in, i_in, j_in;

   // stores
   logic [DIST_W-1:0] dist_mem [DEPTH];
   logic [VIA_W-1:0]  via_mem  [DEPTH];
   logic [DIST_W-1:0] rd_a_ff, rd_b_ff;
   logic [VIA_W-1:0]  via_rd_ff;
   logic [DIST_W-1:0] pivot_ff;

   logic [AW-1:0]     host_addr, rd_a_addr, rd_b_addr, wr_addr;
   logic              host_inside;
   logic [WEIGHT_W-1:0] weight_masked;
   logic [DIST_W-1:0] load_dist;
   logic [DIST_W:0]   relax_sum;
   logic [DIST_W-1:0] relax_cand;
   logic              relax_better;
   logic              wr_en;
   logic [DIST_W-1:0] wr_dist;
   logic [VIA_W-1:0]  wr_via;

   // response
   logic rsp_valid_ff, rsp_done_ff, rsp_inside_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vertex_count_ff <= VERTEX_COUNT_RESET;
      end else if (csr_write_enable) begin
         vertex_count_ff <= csr_write_data;
      end
   end

   // effective vertex count saturates at the store size
   assign count_ext = CW'(vertex_count_ff);
   assign n_eff     = (count_ext > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : count_ext;
   assign last_idx  = VW'(n_eff - CW'(1));

   assign status.last_j = (j_ff == last_idx);
   assign status.last_i = (i_ff == last_idx);
   assign status.last_k = (k_ff == last_idx);
   assign status.n_zero = (count_ext == '0);

   always_comb begin
      k_in = k_ff;
      i_in = i_ff;
      j_in = j_ff;
      if (cmd.cnt_clear) begin
         k_in = '0;
         i_in = '0;
         j_in = '0;
      end else if (cmd.relax) begin
         if (!status.last_j) begin
            j_in = j_ff + VW'(1);
         end else begin
            j_in = '0;
            if (!status.last_i) begin
               i_in = i_ff + VW'(1);
            end else begin
               i_in = '0;
               k_in = k_ff + VW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         k_ff <= '0;
         i_ff <= '0;
         j_ff <= '0;
      end else begin
         k_ff <= k_in;
         i_ff <= i_in;
         j_ff <= j_in;
      end
   end

   // host side address and load value
   assign host_inside = (32'(req_row_vertex) < 32'(MAX_VERTICES)) &&
                        (32'(req_col_vertex) < 32'(MAX_VERTICES));
   assign host_addr   = {VW'(req_row_vertex), VW'(req_col_vertex)};
   assign weight_masked = req_edge_weight & WEIGHT_MASK;
   // zero weight off the diagonal: no edge
   assign load_dist = ((weight_masked == '0) && (req_row_vertex != req_col_vertex)) ?
                      DIST_INF : DIST_W'(weight_masked);

   // saturating relax: any infinite term pushes the sum to or past infinity
   assign relax_sum    = {1'b0, pivot_ff} + {1'b0, rd_a_ff};
   assign relax_cand   = (relax_sum >= {1'b0, DIST_INF}) ? DIST_INF : relax_sum[DIST_W-1:0];
   assign relax_better = (rd_b_ff > relax_cand);

   always_comb begin
      if (cmd.pivot_rd) begin
         rd_a_addr = {i_ff, k_ff};
      end else if (cmd.pair_rd) begin
         rd_a_addr = {k_ff, j_ff};
      end else begin
         rd_a_addr = host_addr;
      end
   end
   assign rd_b_addr = {i_ff, j_ff};

   assign wr_en   = (cmd.host_wr && host_inside) || (cmd.relax && relax_better);
   assign wr_addr = cmd.relax ? {i_ff, j_ff} : host_addr;
   assign wr_dist = cmd.relax ? relax_cand : load_dist;
   assign wr_via  = cmd.relax ? (VIA_W'(k_ff) + VIA_W'(1)) : '0;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         dist_mem[wr_addr] <= wr_dist;
         via_mem[wr_addr]  <= wr_via;
      end
      rd_a_ff   <= dist_mem[rd_a_addr];
      rd_b_ff   <= dist_mem[rd_b_addr];
      via_rd_ff <= via_mem[rd_a_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.pivot_cap) begin
         pivot_ff <= rd_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.host_rd || cmd.finish;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.host_rd) begin
         rsp_done_ff   <= 1'b0;
         rsp_inside_ff <= host_inside;
      end else if (cmd.finish) begin
         rsp_done_ff   <= 1'b1;
         rsp_inside_ff <= 1'b1;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_run_done      = rsp_done_ff;
   assign rsp_path_distance = rsp_done_ff ? '0 : (rsp_inside_ff ? rd_a_ff : DIST_INF);
   assign rsp_unreachable   = !rsp_done_ff && (rsp_path_distance == DIST_INF);
   assign rsp_via_vertex    = (rsp_done_ff || !rsp_inside_ff) ? '0 : via_rd_ff;

endmodule

`default_nettype wire

// ----- src/all_pairs_shortest_path.sv -----
// ---------------------------------------------------------------------------
// all_pairs_shortest_path
// Floyd-Warshall engine: edge load, in-place relaxation run, pair read-back.
// ---------------------------------------------------------------------------
//
// Usage: a word is taken when start is high and busy is low. Load words
// (command 0) and read words (command 2) are taken every cycle while idle;
// a read answers in the cycle after it is taken with a single-cycle rsp_valid
// strobe, and the receiver cannot hold it off, so sample it then. A run word
// (command 1) holds busy high while it walks every (k, i, j) triple over the
// configured vertex count n: each (k, i) pair first fetches d[i][k], then
// each j reads d[k][j] and d[i][j] on the two read ports of the distance
// store, then adds, compares and writes back on its single write port. A
// run ends with one strobe carrying rsp_run_done; with n = 0 the done
// strobe comes the cycle after the word. Command 3 is taken and dropped.
// Write csr_write_data (vertex count, clipped to MAX_VERTICES) only while
// idle. The stores have no reset; read only pairs that were loaded.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "all_pairs_shortest_path_assert.svh"

module all_pairs_shortest_path import apsp_pkg::*; #(
   parameter int MAX_VERTICES = 64,
   parameter int WEIGHT_BITS  = 16
) (
   input  wire logic                clock,
   input  wire logic                reset,
   // request side
   input  wire logic                start,
   output logic                     busy,
   input  wire logic [CMD_W-1:0]    req_command,
   input  wire logic [VERTEX_W-1:0] req_row_vertex,
   input  wire logic [VERTEX_W-1:0] req_col_vertex,
   input  wire logic [WEIGHT_W-1:0] req_edge_weight,
   // response side
   output logic                     rsp_valid,
   output logic [DIST_W-1:0]        rsp_path_distance,
   output logic                     rsp_unreachable,
   output logic [VIA_W-1:0]         rsp_via_vertex,
   output logic                     rsp_run_done,
   // vertex count register
   input  wire logic                csr_write_enable,
   input  wire logic [COUNT_W-1:0]  csr_write_data
);

   apsp_cmd_type    ctrl_cmd;
   apsp_status_type dp_status;

   // sequencer: decodes words and steps the relaxation walk
   apsp_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .command (req_command),
      .status  (dp_status),
      .busy    (busy),
      .cmd     (ctrl_cmd)
   );

   // stores, counters, saturating adder and the response register
   apsp_datapath #(
      .MAX_VERTICES (MAX_VERTICES),
      .WEIGHT_BITS  (WEIGHT_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (ctrl_cmd),
      .status            (dp_status),
      .req_row_vertex    (req_row_vertex),
      .req_col_vertex    (req_col_vertex),
      .req_edge_weight   (req_edge_weight),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_path_distance (rsp_path_distance),
      .rsp_unreachable   (rsp_unreachable),
      .rsp_via_vertex    (rsp_via_vertex),
      .rsp_run_done      (rsp_run_done)
   );

   // a taken read always answers on the next cycle
   `APSP_ASSERT_NEXT(a_read_answers, clock, reset, start && !busy && (req_command == CMD_READ), rsp_valid && !rsp_run_done, "read word got no response next cycle")
   // a run over a nonempty graph goes busy right away
   `APSP_ASSERT_NEXT(a_run_goes_busy, clock, reset, start && !busy && (req_command == CMD_RUN) && !dp_status.n_zero, busy, "run word did not raise busy")
   // busy only drops together with the done strobe
   `APSP_ASSERT_IMPL(a_busy_ends_done, clock, reset, $fell(busy) && !$past(reset), rsp_valid && rsp_run_done, "busy fell without run done")
   // the relax step and store writes from it only happen inside a run
   `APSP_ASSERT_IMPL(a_relax_in_run, clock, reset, ctrl_cmd.relax || ctrl_cmd.pair_rd, busy && !ctrl_cmd.host_wr, "relax step outside a run")

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for the Floyd-Warshall shortest path engine. Edge
// loads, relaxation runs and pair reads are driven through the start/busy
// command port. Every strobed response is checked against a predictor that
// keeps its own copy of the distance and via stores.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import apsp_pkg::*;

   localparam int MAX_VERTICES = 64;
   localparam int STORE_DEPTH  = MAX_VERTICES * MAX_VERTICES;
   // command 3 has no package name: the engine takes it and drops it
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // random part only; the ring job at the end adds about 1220 more words
   localparam int WORD_TARGET   = 480;
   localparam int RING_VERTICES = 34;
   localparam int SETTLE_CYCLES = 4;   // trailing store writes after a load
   localparam int DRAIN_CYCLES  = 8;
   // no word moves while a 34-vertex run is in progress
   localparam int STALL_LIMIT   = 400_000;

   // one response word as seen on the rsp_ ports
   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              unreachable;
      logic [VIA_W-1:0]  via;
      logic              done;
   } path_result_type;

   // hand-written answer for a directed word, used instead of the predictor
   typedef struct {
      bit              given;
      path_result_type result;
   } typed_result_type;

   typedef enum bit {ROW_WORD, ROW_CSR} stim_kind_type;

   // directed row; for ROW_CSR the weight column holds the vertex count
   typedef struct {
      stim_kind_type       kind;
      logic [CMD_W-1:0]    cmd;
      logic [VERTEX_W-1:0] row;
      logic [VERTEX_W-1:0] col;
      logic [WEIGHT_W-1:0] weight;
      bit                  given;
      logic [DIST_W-1:0]   distance;
      logic                unreachable;
      logic [VIA_W-1:0]    via;
      logic                done;
   } stim_row_type;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                start            = 1'b0;
   logic                busy;
   logic [CMD_W-1:0]    req_command      = CMD_LOAD;
   logic [VERTEX_W-1:0] req_row_vertex   = '0;
   logic [VERTEX_W-1:0] req_col_vertex   = '0;
   logic [WEIGHT_W-1:0] req_edge_weight  = '0;
   logic                rsp_valid;
   logic [DIST_W-1:0]   rsp_path_distance;
   logic                rsp_unreachable;
   logic [VIA_W-1:0]    rsp_via_vertex;
   logic                rsp_run_done;
   logic                csr_write_enable = 1'b0;
   logic [COUNT_W-1:0]  csr_write_data   = '0;

   all_pairs_shortest_path DUT (
      .clock,
      .reset,
      .start,
      .busy,
      .req_command,
      .req_row_vertex,
      .req_col_vertex,
      .req_edge_weight,
      .rsp_valid,
      .rsp_path_distance,
      .rsp_unreachable,
      .rsp_via_vertex,
      .rsp_run_done,
      .csr_write_enable,
      .csr_write_data
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Predictor state: the engine's stores and vertex count as they should
   // be. Entries never loaded are never read, so their start value is moot.
   // ------------------------------------------------------------------
   logic [DIST_W-1:0]  model_distance [STORE_DEPTH];
   logic [VIA_W-1:0]   model_via      [STORE_DEPTH];
   logic [COUNT_W-1:0] model_vertex_count;

   path_result_type  pending_results [$];   // responses still owed by the engine
   typed_result_type typed_results   [$];   // one per word presented, in order

   int error_count  = 0;
   int stall_cycles = 0;

   // stimulus-side bookkeeping
   bit pair_loaded [STORE_DEPTH];        // entries safe to read or relax over
   int active_count = VERTEX_COUNT_RESET;
   int idle_pct     = 21;
   int words_sent   = 0;

   // infinity absorbs; finite sums clip at the infinity code
   function automatic logic [DIST_W-1:0] saturating_sum(input logic [DIST_W-1:0] a,
                                                        input logic [DIST_W-1:0] b);
      logic [DIST_W:0] sum;
      if (a == DIST_INF || b == DIST_INF)
         return DIST_INF;
      sum = {1'b0, a} + {1'b0, b};
      return (sum >= DIST_INF) ? DIST_INF : sum[DIST_W-1:0];
   endfunction

   // in-place Floyd-Warshall over the first n vertices, k outermost;
   // only a strictly shorter path replaces an entry
   function automatic void relax_all_pairs();
      int                n;
      logic [DIST_W-1:0] through;
      n = (model_vertex_count > MAX_VERTICES) ? MAX_VERTICES : model_vertex_count;
      for (int k = 0; k < n; k++)
         for (int i = 0; i < n; i++)
            for (int j = 0; j < n; j++) begin
               through = saturating_sum(model_distance[i*MAX_VERTICES + k],
                                        model_distance[k*MAX_VERTICES + j]);
               if (model_distance[i*MAX_VERTICES + j] > through) begin
                  model_distance[i*MAX_VERTICES + j] = through;
                  model_via[i*MAX_VERTICES + j]      = VIA_W'(k + 1);
               end
            end
   endfunction

   // apply one accepted word to the model; says whether a response is owed
   function automatic void predict_word(input logic [CMD_W-1:0] cmd,
                                        input logic [VERTEX_W-1:0] row,
                                        input logic [VERTEX_W-1:0] col,
                                        input logic [WEIGHT_W-1:0] weight,
                                        output bit produces,
                                        output path_result_type res);
      logic [2*VERTEX_W-1:0] addr;
      addr     = {row, col};
      produces = 1'b0;
      res      = '0;
      case (cmd)
         CMD_LOAD: begin
            // zero off the diagonal is "no edge"; 16-bit weights stay finite
            model_distance[addr] = (weight == '0 && row != col) ? DIST_INF
                                                                : DIST_W'(weight);
            model_via[addr]      = '0;
         end
         CMD_RUN: begin
            relax_all_pairs();
            produces = 1'b1;
            res.done = 1'b1;
         end
         CMD_READ: begin
            produces        = 1'b1;
            res.distance    = model_distance[addr];
            res.unreachable = (model_distance[addr] == DIST_INF);
            res.via         = model_via[addr];
         end
         default: ;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Monitor: check the response leaving the engine this cycle first, then
   // record what the word accepted at this edge will owe. One block keeps
   // the order fixed, so a stray strobe cannot match a fresh expectation.
   // ------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      bit               moved;
      bit               produces;
      path_result_type  predicted;
      path_result_type  expected;
      path_result_type  actual;
      typed_result_type typed;
      if (reset) begin
         model_vertex_count = VERTEX_COUNT_RESET;
      end else begin
         moved = 1'b0;
         if (rsp_valid) begin
            moved  = 1'b1;
            actual = {rsp_path_distance, rsp_unreachable, rsp_via_vertex, rsp_run_done};
            if (pending_results.size() == 0) begin
               $display("%0t: response with none expected: dist %0d unr %0d via %0d done %0d",
                        $time, actual.distance, actual.unreachable, actual.via, actual.done);
               error_count++;
            end else begin
               expected = pending_results.pop_front();
               if (actual.distance !== expected.distance) begin
                  $display("%0t: path_distance expected %0d, got %0d",
                           $time, expected.distance, actual.distance);
                  error_count++;
               end
               if (actual.unreachable !== expected.unreachable) begin
                  $display("%0t: unreachable expected %0d, got %0d",
                           $time, expected.unreachable, actual.unreachable);
                  error_count++;
               end
               if (actual.via !== expected.via) begin
                  $display("%0t: via_vertex expected %0d, got %0d",
                           $time, expected.via, actual.via);
                  error_count++;
               end
               if (actual.done !== expected.done) begin
                  $display("%0t: run_done expected %0d, got %0d",
                           $time, expected.done, actual.done);
                  error_count++;
               end
            end
         end
         if (csr_write_enable) begin
            moved              = 1'b1;
            model_vertex_count = csr_write_data;
         end
         if (start && !busy) begin
            moved = 1'b1;
            typed = typed_results.pop_front();
            predict_word(req_command, req_row_vertex, req_col_vertex, req_edge_weight,
                         produces, predicted);
            if (produces)
               pending_results.push_back(typed.given ? typed.result : predicted);
         end
         stall_cycles = moved ? 0 : stall_cycles + 1;
      end
   end

   initial begin : watchdog
      wait (stall_cycles >= STALL_LIMIT);
      $display("TEST FAILED");
      $finish;
   end

   // weights skewed toward no-edge, the maximum and small values, so that
   // relaxations actually fire and long chains of heavy edges appear
   function automatic logic [WEIGHT_W-1:0] random_weight();
      case ($urandom_range(9))
         0, 1, 2: return '0;
         3:       return '1;
         4, 5, 6: return WEIGHT_W'($urandom_range(1, 20));
         default: return WEIGHT_W'($urandom_range(0, 16'hFFFF));
      endcase
   endfunction

   // Present one word and hold it until the engine takes it. Returns at the
   // accepting edge with start still high, so a following word can go out
   // back to back without start dropping in between. Each cycle before the
   // word is idle with probability idle_pct percent.
   task automatic send_word(input logic [CMD_W-1:0] cmd,
                            input logic [VERTEX_W-1:0] row,
                            input logic [VERTEX_W-1:0] col,
                            input logic [WEIGHT_W-1:0] weight,
                            input bit given,
                            input path_result_type typed);
      typed_result_type entry;
      entry.given  = given;
      entry.result = typed;
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < idle_pct) @(posedge clock);
      end
      typed_results.push_back(entry);
      start           <= 1'b1;
      req_command     <= cmd;
      req_row_vertex  <= row;
      req_col_vertex  <= col;
      req_edge_weight <= weight;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (cmd == CMD_LOAD)
         pair_loaded[{row, col}] = 1'b1;
      if (cmd != CMD_UNUSED)
         words_sent++;
   endtask

   // The count register may only change while the engine is idle: every
   // owed response in, busy low, and a few cycles for load write-back.
   task automatic write_vertex_count(input logic [COUNT_W-1:0] value);
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0 || busy) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      active_count = (value > MAX_VERTICES) ? MAX_VERTICES : value;
   endtask

   // Directed table. A 3-vertex graph is loaded, spot-checked, relaxed and
   // read back; then empty and single-vertex runs, the far corner of the
   // store, and a load after a run to check that the via entry clears.
   stim_row_type directed_table [29] = '{
      '{ROW_CSR,  CMD_LOAD,   6'd0,  6'd0,  16'd3,     1'b0, 22'd0,    1'b0, 7'd0, 1'b0},
      // diagonal zero is a real zero
      '{ROW_WORD, CMD_LOAD,   6'd0,  6'd0,  16'd0,     1'b0, 22'd0,    1'b0, 7'd0, 1'b0},
      '{ROW_WORD, CMD_LOAD,   6'd0,  6'd1,  16'd5,     1'b0, 22'd0,    1'b0, 7'd0, 1'b0},
      // off-diagonal zero: no edge
      '{ROW_WORD, CMD_LOAD,   6'd0,  6'd2,  16'd0,     1'b0, 22'd0,    1'b0, 7'd0, 1'b0},
      '{ROW_WORD, CMD_LOAD,   6'd1,  6'd0,  16'd0,     1'b0, 22'd0,    1'b0, 7'd0, 1'b0},
      '{ROW_WORD, CMD_LOAD,   6'd1,  6'd1,  16'hFFFF,  1'b0, 22'd0,    1'b0, 7'd0, 1'b0},
      '{ROW_WORD, CMD_LOAD,   6'd1,  6'd2,  16'd7,     1'b0, 22'd0,    1'b0, 7'd0, 1'b0},
      '{ROW_WORD, CMD_LOAD,   6'd2,  6'd0,  16'hFFFF,  1'b0, 22'd0,    1'b0, 7'd0, 1'b0},
      '{ROW_WORD, CMD_LOAD,   6'd2,  6'd1,  16'd1,     1'b0, 22'd0,    1'b0, 7'd0, 1'b0},
      '{ROW_WORD, CMD_LOAD,   6'd2,  6'd2,  16'd0,     1'b0, 22'd0,    1'b0, 7'd0, 1'b0},
      '{ROW_WORD, CMD_READ,   6'd0,  6'd0,  16'd0,     1'b1, 22'd0,    1'b0, 7'd0, 1'b0},
      '{ROW_WORD, CMD_READ,   6'd0,  6'd2,  16'd0,     1'b1, DIST_INF, 1'b1, 7'd0, 1'b0},
      '{ROW_WORD, CMD_READ,   6'd2,  6'd0,  16'd0,     1'b1, 22'd65535, 1'b0, 7'd0, 1'b0},
      // unused command: taken, no response
      '{ROW_WORD, CMD_UNUSED, 6'd63, 6'd63, 16'hFFFF,  1'b0, 22'd0,    1'b0, 7'd0, 1'b0},
      '{ROW_WORD, CMD_RUN,    6'd0,  6'd0,  16'd0,     1'b1, 22'd0,    1'b0, 7'd0, 1'b1},
      '{ROW_WORD, CMD_READ,   6'd0,  6'd2,  16'd0,     1'b0, 22'd0,    1'b0, 7'd0, 1'b0},
      '{ROW_WORD, CMD_READ,   6'd1,  6'd1,  16'd0,     1'b0, 22'd0,    1'b0, 7'd0, 1'b0},
      '{ROW_WORD, CMD_READ,   6'd1,  6'd0,  16'd0,     1'b0, 22'd0,    1'b0, 7'd0, 1'b0},
      // zero vertices: nothing relaxed, done still reported
      '{ROW_CSR,  CMD_LOAD,   6'd0,  6'd0,  16'd0,     1'b0, 22'd0,    1'b0, 7'd0, 1'b0},
      '{ROW_WORD, CMD_RUN,    6'd0,  6'd0,  16'd0,     1'b1, 22'd0,    1'b0, 7'd0, 1'b1},
      '{ROW_CSR,  CMD_LOAD,   6'd0,  6'd0,  16'd1,     1'b0, 22'd0,    1'b0, 7'd0, 1'b0},
      '{ROW_WORD, CMD_RUN,    6'd63, 6'd63, 16'hFFFF,  1'b1, 22'd0,    1'b0, 7'd0, 1'b1},
      '{ROW_WORD, CMD_READ,   6'd0,  6'd0,  16'd0,     1'b0, 22'd0,    1'b0, 7'd0, 1'b0},
      '{ROW_WORD, CMD_LOAD,   6'd63, 6'd63, 16'hFFFF,  1'b0, 22'd0,    1'b0, 7'd0, 1'b0},
      '{ROW_WORD, CMD_READ,   6'd63, 6'd63, 16'd0,     1'b1, 22'd65535, 1'b0, 7'd0, 1'b0},
      '{ROW_WORD, CMD_LOAD,   6'd63, 6'd0,  16'd0,     1'b0, 22'd0,    1'b0, 7'd0, 1'b0},
      '{ROW_WORD, CMD_READ,   6'd63, 6'd0,  16'd0,     1'b1, DIST_INF, 1'b1, 7'd0, 1'b0},
      // reload of a relaxed pair: via goes back to direct
      '{ROW_WORD, CMD_LOAD,   6'd0,  6'd2,  16'd3,     1'b0, 22'd0,    1'b0, 7'd0, 1'b0},
      '{ROW_WORD, CMD_READ,   6'd0,  6'd2,  16'd0,     1'b1, 22'd3,    1'b0, 7'd0, 1'b0}
   };

   initial begin : stimulus
      int                  n;
      int                  pick;
      int                  r;
      int                  c;
      logic [WEIGHT_W-1:0] w;
      path_result_type     typed;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // ---------------- directed part ----------------
      foreach (directed_table[idx]) begin
         if (directed_table[idx].kind == ROW_CSR) begin
            write_vertex_count(directed_table[idx].weight[COUNT_W-1:0]);
         end else begin
            typed = {directed_table[idx].distance, directed_table[idx].unreachable,
                     directed_table[idx].via, directed_table[idx].done};
            send_word(directed_table[idx].cmd, directed_table[idx].row,
                      directed_table[idx].col, directed_table[idx].weight,
                      directed_table[idx].given, typed);
         end
      end

      // ---------------- random part ----------------
      // Each pass is a well-formed job: set the vertex count, make sure the
      // whole n-by-n square is loaded (a run reads all of it), sprinkle some
      // noise, run, and read results back. Sizes stay small so runs are short.
      while (words_sent < WORD_TARGET) begin
         idle_pct = (words_sent < WORD_TARGET / 3)     ? 21 :
                    (words_sent < 2 * WORD_TARGET / 3) ? 80 : 0;
         pick = $urandom_range(9);
         n = (pick == 0) ? 0 :
             (pick < 3)  ? $urandom_range(1, 2) :
             (pick < 9)  ? $urandom_range(3, 8) : $urandom_range(9, 12);
         write_vertex_count(COUNT_W'(n));
         for (r = 0; r < active_count; r++)
            for (c = 0; c < active_count; c++)
               if (!pair_loaded[r*MAX_VERTICES + c] || $urandom_range(3) == 0)
                  send_word(CMD_LOAD, VERTEX_W'(r), VERTEX_W'(c), random_weight(),
                            1'b0, '0);
         // noise anywhere in the store; reads only hit loaded pairs
         repeat ($urandom_range(0, 3)) begin
            r = $urandom_range(MAX_VERTICES - 1);
            c = $urandom_range(MAX_VERTICES - 1);
            case ($urandom_range(3))
               0:
                  send_word(CMD_LOAD, VERTEX_W'(r), VERTEX_W'(c), random_weight(),
                            1'b0, '0);
               1, 2:
                  send_word(pair_loaded[r*MAX_VERTICES + c] ? CMD_READ : CMD_LOAD,
                            VERTEX_W'(r), VERTEX_W'(c), random_weight(), 1'b0, '0);
               default:
                  send_word(CMD_UNUSED, VERTEX_W'(r), VERTEX_W'(c),
                            WEIGHT_W'($urandom_range(16'hFFFF)), 1'b0, '0);
            endcase
         end
         send_word(CMD_RUN, VERTEX_W'($urandom_range(63)), VERTEX_W'($urandom_range(63)),
                   WEIGHT_W'($urandom_range(16'hFFFF)), 1'b0, '0);
         // sometimes a second run straight behind the first, against busy
         if ($urandom_range(4) == 0)
            send_word(CMD_RUN, '0, '0, '0, 1'b0, '0);
         if (active_count > 0) begin
            repeat ($urandom_range(1, active_count * active_count + 1)) begin
               r = $urandom_range(active_count - 1);
               c = $urandom_range(active_count - 1);
               send_word(CMD_READ, VERTEX_W'(r), VERTEX_W'(c), '0, 1'b0, '0);
            end
         end
      end

      // ---------------- ring run ----------------
      // A ring of near-maximum edges over 34 vertices gives shortest paths
      // of up to 33 hops; at the late pivots two of them added together run
      // past the infinity code and must saturate rather than wrap.
      idle_pct = 0;
      write_vertex_count(COUNT_W'(RING_VERTICES));
      for (r = 0; r < RING_VERTICES; r++)
         for (c = 0; c < RING_VERTICES; c++) begin
            if (c == (r + 1) % RING_VERTICES)
               w = WEIGHT_W'($urandom_range(65000, 65535));
            else if (r == c || $urandom_range(99) >= 3)
               w = '0;
            else
               w = random_weight();
            send_word(CMD_LOAD, VERTEX_W'(r), VERTEX_W'(c), w, 1'b0, '0);
         end
      send_word(CMD_RUN, '0, '0, '0, 1'b0, '0);
      send_word(CMD_READ, 6'd0, VERTEX_W'(RING_VERTICES - 1), '0, 1'b0, '0);
      send_word(CMD_READ, VERTEX_W'(RING_VERTICES - 1), 6'd0, '0, 1'b0, '0);
      send_word(CMD_READ, 6'd1, 6'd0, '0, 1'b0, '0);
      repeat (60)
         send_word(CMD_READ, VERTEX_W'($urandom_range(RING_VERTICES - 1)),
                   VERTEX_W'($urandom_range(RING_VERTICES - 1)), '0, 1'b0, '0);

      // drain: every owed response in, then a short tail for stray strobes
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
